@@ src/latin1_key_character_composer_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Latin-1 key character composer
// Shared property shells. Each expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef LATIN1_KEY_CHARACTER_COMPOSER_DEFINES_SVH
`define LATIN1_KEY_CHARACTER_COMPOSER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LKC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define LKC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lkc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkc_pkg
// Types, constants and lookup functions of the Latin-1 key character composer.
// ----------------------------------------------------------------------------
`default_nettype none

package lkc_pkg;

  localparam int unsigned JOB_FIFO_DEPTH = 2;

  localparam logic       OP_CHAR   = 1'b0;
  localparam logic       OP_DEAD   = 1'b1;

  localparam logic [2:0] NO_ACCENT  = 3'd7;
  localparam logic [7:0] MAX_ACCENT = 8'd4;

  localparam logic [7:0] ESC_CHAR   = 8'h1b;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] DEL_CHAR   = 8'd127;
  localparam logic [7:0] CTRL_MASK  = 8'h1f;
  localparam logic [7:0] META_BIT   = 8'h80;
  localparam logic [7:0] CASE_DELTA = 8'd32;
  localparam logic [7:0] DIGIT_CTRL = 8'd24;

  typedef struct packed {
    logic       operation;
    logic [7:0] key_value;
    logic       key_released;
    logic       caps_lock;
    logic       ctrl_held;
    logic       alt_held;
    logic       meta_escape;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_item_t;

  // One queued job: the final byte, and whether an ESC beat goes first.
  typedef struct packed {
    logic [7:0] char_code;
    logic       esc_first;
  } job_t;

  // Accented forms; columns follow the letters A E I O U Y N a e i o u y n.
  // A zero entry means the letter has no form for that accent.
  localparam logic [7:0] ACCENT_FORM [5][14] = '{
    '{8'hC0, 8'hC8, 8'hCC, 8'hD2, 8'hD9, 8'h00, 8'h00,
      8'hE0, 8'hE8, 8'hEC, 8'hF2, 8'hF9, 8'h00, 8'h00},
    '{8'hC1, 8'hC9, 8'hCD, 8'hD3, 8'hDA, 8'hDD, 8'h00,
      8'hE1, 8'hE9, 8'hED, 8'hF3, 8'hFA, 8'hFD, 8'h00},
    '{8'hC2, 8'hCA, 8'hCE, 8'hD4, 8'hDB, 8'h00, 8'h00,
      8'hE2, 8'hEA, 8'hEE, 8'hF4, 8'hFB, 8'h00, 8'h00},
    '{8'hC3, 8'h00, 8'h00, 8'hD5, 8'h00, 8'h00, 8'hD1,
      8'hE3, 8'h00, 8'h00, 8'hF5, 8'h00, 8'h00, 8'hF1},
    '{8'hC4, 8'hCB, 8'hCF, 8'hD6, 8'hDC, 8'h00, 8'h00,
      8'hE4, 8'hEB, 8'hEF, 8'hF6, 8'hFC, 8'hFF, 8'h00}
  };

  // Spacing form of each accent.
  function automatic logic [7:0] accent_char(input logic [2:0] acc);
    logic [7:0] c;
    case (acc)
      3'd0:    c = 8'h60;
      3'd1:    c = 8'h27;
      3'd2:    c = 8'h5e;
      3'd3:    c = 8'h7e;
      3'd4:    c = 8'h22;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Column of a base letter in ACCENT_FORM; bit 4 flags a hit.
  function automatic logic [4:0] letter_index(input logic [7:0] ch);
    logic [4:0] r;
    case (ch)
      8'h41:   r = {1'b1, 4'd0};
      8'h45:   r = {1'b1, 4'd1};
      8'h49:   r = {1'b1, 4'd2};
      8'h4f:   r = {1'b1, 4'd3};
      8'h55:   r = {1'b1, 4'd4};
      8'h59:   r = {1'b1, 4'd5};
      8'h4e:   r = {1'b1, 4'd6};
      8'h61:   r = {1'b1, 4'd7};
      8'h65:   r = {1'b1, 4'd8};
      8'h69:   r = {1'b1, 4'd9};
      8'h6f:   r = {1'b1, 4'd10};
      8'h75:   r = {1'b1, 4'd11};
      8'h79:   r = {1'b1, 4'd12};
      8'h6e:   r = {1'b1, 4'd13};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/latin1_key_character_composer.sv @@
// ----------------------------------------------------------------------------
// latin1_key_character_composer
// Dead-key accent composer producing Latin-1 bytes for a terminal queue.
// ----------------------------------------------------------------------------
// Usage: key events enter on the in channel (in_valid_i, in_item_i, in_stall_o)
// and character bytes leave on the out channel (out_valid_o, out_item_o,
// out_stall_i). A beat moves at a rising edge with valid high and stall low.
// Each press event yields zero, one or two output beats; the final beat of an
// event carries last set. Releases and dropped control keys yield none; an
// accent press yields none but still updates the pending accent, and a repeat
// of the pending accent yields its spacing form. An accepted event is queued
// and then loaded into the output register. Events that yield at most one
// beat flow at one per cycle while out_stall_i is low. An event with alt in
// ESC mode puts the ESC beat and then the byte out from one shared queue entry.
// The front end classifies and composes in the accept cycle and writes a job
// into a short queue; in_stall_o rises only while that queue is full, so a
// stalled receiver backs up into the queue before it stalls the sender.
// Reset clears the pending accent to none, empties the queue and drops the
// output register; no item is accepted or shown until reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module latin1_key_character_composer #(
  parameter int unsigned JobFifoDepth = lkc_pkg::JOB_FIFO_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire lkc_pkg::in_item_t  in_item_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  output lkc_pkg::out_item_t      out_item_o,
  input  wire logic               out_stall_i
);
  import lkc_pkg::*;

  // Queue handshake between the front and back halves.
  logic job_push;
  job_t job_in;
  logic job_full;
  logic job_pop;
  logic head_valid;
  job_t head;

  // Front: pending-accent state, composition, caps, ctrl and alt rules.
  lkc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  // Decoupling queue: lets the front keep accepting while output is stalled.
  lkc_fifo #(
    .Depth (JobFifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_push),
    .push_data_i  (job_in),
    .full_o       (job_full),
    .pop_i        (job_pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Back: expands each job into its beats behind a registered output.
  lkc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (job_pop),
    .out_valid_o  (out_valid_o),
    .out_item_o   (out_item_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

`default_nettype wire

@@ src/lkc_front.sv @@
// ----------------------------------------------------------------------------
// lkc_front
// Accepts key events, tracks the pending accent and builds output jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module lkc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire lkc_pkg::in_item_t in_item_i,
  output logic                   in_stall_o,
  input  wire logic              job_full_i,
  output logic                   job_push_o,
  output lkc_pkg::job_t          job_o
);
  import lkc_pkg::*;

  logic [2:0] pend_q, pend_d;
  logic       in_fire;
  logic [4:0] lidx;
  logic [7:0] form;
  logic [7:0] composed;
  logic [7:0] cased;
  logic [7:0] ctrl_ch;
  logic       ctrl_keep;
  logic [7:0] fin_ch;

  assign in_stall_o = job_full_i;
  assign in_fire    = in_valid_i && !job_full_i;
  assign lidx       = letter_index(in_item_i.key_value);

  always_comb begin
    form     = 8'h00;
    composed = in_item_i.key_value;
    if (pend_q <= MAX_ACCENT[2:0]) begin
      form = ACCENT_FORM[pend_q][lidx[3:0]];
      if (in_item_i.key_value == SPACE_CHAR) begin
        composed = accent_char(pend_q);
      end else if (lidx[4] && form != 8'h00) begin
        composed = form;
      end
    end
  end

  always_comb begin
    cased = composed;
    if (in_item_i.caps_lock &&
        ((composed >= 8'h61 && composed <= 8'h7a) ||
         (composed >= 8'd224 && composed <= 8'd254))) begin
      cased = composed - CASE_DELTA;
    end
  end

  always_comb begin
    ctrl_ch   = cased;
    ctrl_keep = 1'b1;
    if (in_item_i.ctrl_held) begin
      if (cased >= 8'd64 && cased < DEL_CHAR) begin
        ctrl_ch = cased & CTRL_MASK;
      end else if (cased == SPACE_CHAR || cased == 8'h32) begin
        ctrl_ch = 8'h00;
      end else if (cased >= 8'h33 && cased < 8'h38) begin
        ctrl_ch = cased - DIGIT_CTRL;
      end else if (cased == 8'h3f || cased == 8'h38 || cased == 8'h2f) begin
        ctrl_ch = DEL_CHAR;
      end else if (cased == 8'h2d) begin
        ctrl_ch = CTRL_MASK;
      end else begin
        ctrl_keep = 1'b0;
      end
    end
  end

  assign fin_ch = (in_item_i.alt_held && !in_item_i.meta_escape) ? (ctrl_ch | META_BIT)
                                                                  : ctrl_ch;

  always_comb begin
    pend_d     = pend_q;
    job_push_o = 1'b0;
    job_o      = '0;
    if (in_fire && !in_item_i.key_released) begin
      if (in_item_i.operation == OP_DEAD) begin
        if (in_item_i.key_value <= MAX_ACCENT) begin
          if (pend_q == in_item_i.key_value[2:0]) begin
            pend_d          = NO_ACCENT;
            job_push_o      = 1'b1;
            job_o.char_code = accent_char(pend_q);
            job_o.esc_first = 1'b0;
          end else begin
            pend_d = in_item_i.key_value[2:0];
          end
        end
      end else begin
        pend_d          = NO_ACCENT;
        job_push_o      = ctrl_keep;
        job_o.char_code = fin_ch;
        job_o.esc_first = in_item_i.alt_held && in_item_i.meta_escape;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= NO_ACCENT;
    end else begin
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

@@ src/lkc_fifo.sv @@
// ----------------------------------------------------------------------------
// lkc_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lkc_fifo #(
  parameter int unsigned Depth = lkc_pkg::JOB_FIFO_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire lkc_pkg::job_t  push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                head_valid_o,
  output lkc_pkg::job_t       head_o
);
  import lkc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ src/lkc_back.sv @@
// ----------------------------------------------------------------------------
// lkc_back
// Drains jobs into output beats: an optional ESC beat, then the byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "latin1_key_character_composer_defines.svh"

module lkc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               head_valid_i,
  input  wire lkc_pkg::job_t      head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  output lkc_pkg::out_item_t      out_item_o,
  input  wire logic               out_stall_i
);
  import lkc_pkg::*;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      phase_q, phase_d;
  logic      load;
  logic      out_fire;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign load        = !out_valid_q || !out_stall_i;
  assign out_fire    = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    phase_d     = phase_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        if (head_i.esc_first && !phase_q) begin
          out_d.char_code = ESC_CHAR;
          out_d.last      = 1'b0;
          phase_d         = 1'b1;
        end else begin
          out_d.char_code = head_i.char_code;
          out_d.last      = 1'b1;
          phase_d         = 1'b0;
          pop_o           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // The job whose ESC went out must still be at the head of the queue.
  `LKC_ASSERT_IMPL(a_phase_has_job, phase_q, head_valid_i, "ESC sent but job lost")
  // Only the ESC prefix is ever a non-final beat.
  `LKC_ASSERT_IMPL(a_nonlast_is_esc, out_valid_q && !out_q.last, out_q.char_code == ESC_CHAR, "bad prefix")
  // The byte follows its ESC prefix directly.
  `LKC_ASSERT_NEXT(a_esc_then_byte, out_fire && !out_q.last, out_valid_q && out_q.last, "gap after ESC")

endmodule

`default_nettype wire
